[rtl/core/black_pixel_neighbor_fill_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the black pixel neighbor fill unit
// Both macros sample on clk and are off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLACK_PIXEL_NEIGHBOR_FILL_UNIT_ASSERT_SVH
`define BLACK_PIXEL_NEIGHBOR_FILL_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BPNF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BPNF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/bpnf_pkg.sv]
// ----------------------------------------------------------------------------
// bpnf_pkg
// Types and fixed constants of the black pixel neighbor fill unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bpnf_pkg;

	localparam int CH_W          = 8;
	localparam int PIX_ROW_W     = 16;
	localparam int PIX_COL_W     = 11;
	localparam int IMAGE_WIDTH_W = 12;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_IDX_W     = 1;

	localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
	localparam logic [PIX_ROW_W-1:0]     IMAGE_HEIGHT_RST = 16'd480;

	// neighbor sums: up to eight 8-bit values
	localparam int SUM_W = 11;

	// floor(s/3) = (s*683)>>11 for s < 1024, floor(s/5) = (s*1639)>>13 for s < 2048
	localparam int RECIP3_W  = 10;
	localparam int RECIP3_SH = 11;
	localparam int RECIP5_W  = 11;
	localparam int RECIP5_SH = 13;
	localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;
	localparam logic [RECIP5_W-1:0] RECIP5 = 11'd1639;
	localparam int P3_W = SUM_W + RECIP3_W;
	localparam int P5_W = SUM_W + RECIP5_W;

	typedef logic [CH_W-1:0]      chan_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [PIX_ROW_W-1:0] pix_row_t;
	typedef logic [PIX_COL_W-1:0] pix_col_t;

	// [2] red, [1] green, [0] blue
	typedef logic [2:0][CH_W-1:0] rgb_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		chan_t red_in;
		chan_t green_in;
		chan_t blue_in;
	} pix_in_t;

	typedef struct packed {
		pix_row_t pixel_row;
		pix_col_t pixel_col;
		chan_t    red_out;
		chan_t    green_out;
		chan_t    blue_out;
		logic     run_last;
		logic     frame_done;
	} pix_out_t;

endpackage

`default_nettype wire

[rtl/core/black_pixel_neighbor_fill_unit.sv]
// ----------------------------------------------------------------------------
// black_pixel_neighbor_fill_unit
// Streaming fill of all-zero RGB pixels with the truncated mean of their
// 3, 5 or 8 in-frame neighbors, done in place in raster order.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | item
//  ---------+------------------------------+-----------------------------------
//  pixel    | pixel_valid / pixel_ready    | one raw pixel, raster order
//  result   | result_valid / result_ready  | one emitted pixel with row, column
//  cfg      | cfg_we (no wait)             | image_width / image_height write
//
//  One pixel per cycle while result_ready is high and each pixel gives at
//  most one result. A pixel in the last column gives two, and in the last
//  row up to three, and then the result port (one result per cycle while
//  result_ready is high) sets the pace. A pixel is registered in s1, and
//  its results in the result register s2. Reset clears counters, bank
//  rotation and valid flags; the line memories are not cleared (an entry
//  is used only after it was written). result_ready low holds the result
//  register, then the compute stage, then drops pixel_ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "black_pixel_neighbor_fill_unit_assert.svh"

module black_pixel_neighbor_fill_unit
	import bpnf_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// pixel stream
	input  wire logic                 pixel_valid,
	output      logic                 pixel_ready,
	input  wire pix_in_t              pixel,
	// corrected stream
	output      logic                 result_valid,
	input  wire logic                 result_ready,
	output      pix_out_t             result
);

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int NUM_BANKS = 3;
	localparam int NUM_NB    = 8;

	typedef logic [COL_W-1:0] col_t;
	typedef logic [1:0]       bank_t;
	typedef enum logic [1:0] {NB_3, NB_5, NB_8} nb_cnt_t;

	// last column index for a width register value (0 acts as 1, clamp to MAX_WIDTH)
	function automatic col_t width_to_last(input logic [IMAGE_WIDTH_W-1:0] v);
		col_t last;
		if (v == '0) begin
			last = '0;
		end else if (32'(v) > MAX_WIDTH) begin
			last = COL_W'(MAX_WIDTH - 1);
		end else begin
			last = COL_W'(v - 1'b1);
		end
		return last;
	endfunction

	function automatic pix_row_t height_to_last(input pix_row_t v);
		return (v == '0) ? '0 : v - 1'b1;
	endfunction

	function automatic bank_t bank_inc(input bank_t b);
		return (b == bank_t'(NUM_BANKS - 1)) ? '0 : b + 1'b1;
	endfunction

	// truncated mean by reciprocal multiply, or shift for eight
	function automatic chan_t nb_mean(input sum_t s, input nb_cnt_t cnt);
		logic [P3_W-1:0] p3;
		logic [P5_W-1:0] p5;
		chan_t           m;
		p3 = P3_W'(s) * P3_W'(RECIP3);
		p5 = P5_W'(s) * P5_W'(RECIP5);
		case (cnt)
			NB_3:    m = chan_t'(p3 >> RECIP3_SH);
			NB_5:    m = chan_t'(p5 >> RECIP5_SH);
			NB_8:    m = chan_t'(s >> 3);
			default: m = '0;
		endcase
		return m;
	endfunction

	// ------------------------------------------------------------------
	// configuration, stored as last column / last row indexes
	// ------------------------------------------------------------------
	col_t     width_last_q;
	pix_row_t height_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q  <= width_to_last(IMAGE_WIDTH_RST);
			height_last_q <= height_to_last(IMAGE_HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_last_q  <= width_to_last(cfg_data[IMAGE_WIDTH_W-1:0]);
				REG_IMAGE_HEIGHT: height_last_q <= height_to_last(cfg_data);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// input side: raster counters and line-bank rotation
	// bank_q is the above bank; current is bank_q+1, below is bank_q+2 (mod 3).
	// At end of row the roles rotate instead of copying lines.
	// ------------------------------------------------------------------
	col_t     col_q;
	pix_row_t row_q;
	bank_t    bank_q;

	logic  pix_accept;
	logic  last_col_in;
	logic  last_row_in;
	bank_t cur_bank_in;
	bank_t raw_bank;
	rgb_t  pix_rgb;

	assign pix_accept  = pixel_valid && pixel_ready;
	assign last_col_in = (col_q >= width_last_q);
	assign last_row_in = (row_q >= height_last_q);
	assign cur_bank_in = bank_inc(bank_q);
	assign raw_bank    = bank_inc(cur_bank_in);
	assign pix_rgb     = {pixel.red_in, pixel.green_in, pixel.blue_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			bank_q <= '0;
		end else if (pix_accept) begin
			if (last_col_in) begin
				col_q  <= '0;
				row_q  <= last_row_in ? '0 : row_q + 1'b1;
				bank_q <= cur_bank_in;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// compute stage s1 (declared early: its writeback feeds the memories)
	// ------------------------------------------------------------------
	logic     valid_s1;
	rgb_t     pix_s1;
	pix_row_t row_s1;
	col_t     col_s1;
	logic     last_col_s1;
	logic     last_row_s1;
	bank_t    bank_s1;
	logic     byp_a_s1;
	logic     byp_c_s1;
	rgb_t     byp_d_s1;
	rgb_t     rd_s1 [NUM_BANKS];

	logic  s1_adv;
	logic  fix_we;
	bank_t fix_bank;
	col_t  fix_addr;
	rgb_t  fix_data;
	logic  byp_a;
	logic  byp_c;

	// A fill written back this edge may be the entry an accepted pixel reads
	// (two-pixel rows only); the read returns old data, so carry the new one.
	assign byp_a = fix_we && (fix_bank == bank_q) && (fix_addr == col_q);
	assign byp_c = fix_we && (fix_bank == cur_bank_in) && (fix_addr == col_q);

	// ------------------------------------------------------------------
	// line memories: raw pixel goes to the below bank at accept, a filled
	// pixel goes back to the current bank when it leaves s1. Both reads
	// (above[c], current[c]) are issued at accept.
	// ------------------------------------------------------------------
	rgb_t line_mem [NUM_BANKS][MAX_WIDTH];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			if (pix_accept && (raw_bank == bank_t'(k))) begin
				line_mem[k][col_q] <= pix_rgb;
			end else if (fix_we && (fix_bank == bank_t'(k))) begin
				line_mem[k][fix_addr] <= fix_data;
			end
			if (pix_accept) begin
				rd_s1[k] <= line_mem[k][col_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			pix_s1      <= pix_rgb;
			row_s1      <= row_q;
			col_s1      <= col_q;
			last_col_s1 <= last_col_in;
			last_row_s1 <= last_row_in;
			bank_s1     <= bank_q;
			byp_a_s1    <= byp_a;
			byp_c_s1    <= byp_c;
			byp_d_s1    <= fix_data;
		end
	end

	// 3x3 window history, shifted as each pixel leaves s1:
	// b1/b2 below[j]/below[j-1], c1 current[j] (raw), c2 current[j-1] (filled),
	// a1/a2 above[j]/above[j-1]. j = c-1.
	rgb_t b1_q, b2_q, c1_q, c2_q, a1_q, a2_q;

	rgb_t    above_c;
	rgb_t    cur_c;
	logic    row_ge1, row_ge2, col_ge1, col_ge2;
	logic    is_black;
	nb_cnt_t nb_cnt;
	rgb_t    nb [NUM_NB];
	sum_t    nb_sum [3];
	rgb_t    mean;
	rgb_t    v_s1;
	logic [2:0] emit_s1;

	assign above_c = byp_a_s1 ? byp_d_s1 : rd_s1[bank_s1];
	assign cur_c   = byp_c_s1 ? byp_d_s1 : rd_s1[bank_inc(bank_s1)];
	assign row_ge1 = (row_s1 != '0);
	assign row_ge2 = (row_s1[PIX_ROW_W-1:1] != '0);
	assign col_ge1 = (col_s1 != '0);
	assign col_ge2 = (col_s1 > col_t'(1));
	assign is_black = (c1_q == '0);

	always_comb begin
		nb[0] = cur_c;
		nb[1] = pix_s1;
		nb[2] = b1_q;
		nb[3] = col_ge2 ? b2_q : '0;
		nb[4] = col_ge2 ? c2_q : '0;
		nb[5] = row_ge2 ? a1_q : '0;
		nb[6] = row_ge2 ? above_c : '0;
		nb[7] = (row_ge2 && col_ge2) ? a2_q : '0;

		if (row_ge2 && col_ge2) begin
			nb_cnt = NB_8;
		end else if (row_ge2 || col_ge2) begin
			nb_cnt = NB_5;
		end else begin
			nb_cnt = NB_3;
		end

		for (int ch = 0; ch < 3; ch++) begin
			nb_sum[ch] = '0;
			for (int n = 0; n < NUM_NB; n++) begin
				nb_sum[ch] = nb_sum[ch] + SUM_W'(nb[n][ch]);
			end
			mean[ch] = nb_mean(nb_sum[ch], nb_cnt);
		end
	end

	assign v_s1 = is_black ? mean : c1_q;

	// results: [0] pixel (r-1,c-1), [1] last column (r-1,c), [2] last row (r,c)
	assign emit_s1 = {last_row_s1, row_ge1 && last_col_s1, row_ge1 && col_ge1};

	assign fix_we   = s1_adv && emit_s1[0] && is_black;
	assign fix_bank = bank_inc(bank_s1);
	assign fix_addr = col_s1 - 1'b1;
	assign fix_data = v_s1;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			b2_q <= b1_q;
			b1_q <= pix_s1;
			c2_q <= v_s1;
			c1_q <= cur_c;
			a2_q <= a1_q;
			a1_q <= above_c;
		end
	end

	// ------------------------------------------------------------------
	// result register s2: up to three results of one pixel, sent lowest first
	// ------------------------------------------------------------------
	logic [2:0] mask_s2;
	pix_row_t   row_s2;
	col_t       col_s2;
	logic       last_col_s2;
	rgb_t       fill_s2;
	rgb_t       curc_s2;
	rgb_t       pix_s2;

	logic [2:0] pick;
	logic [2:0] rest;
	logic       take;
	logic       emit_free;
	rgb_t       out_rgb;

	assign pick      = mask_s2 & (~mask_s2 + 1'b1);
	assign rest      = mask_s2 & ~pick;
	assign take      = result_valid && result_ready;
	assign emit_free = !result_valid || (result_ready && (rest == '0));
	assign s1_adv    = valid_s1 && emit_free;
	assign pixel_ready = !valid_s1 || emit_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (s1_adv) begin
			mask_s2 <= emit_s1;
		end else if (take) begin
			mask_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			row_s2      <= row_s1;
			col_s2      <= col_s1;
			last_col_s2 <= last_col_s1;
			fill_s2     <= v_s1;
			curc_s2     <= cur_c;
			pix_s2      <= pix_s1;
		end
	end

	assign result_valid = (mask_s2 != '0);

	always_comb begin
		if (pick[0]) begin
			out_rgb = fill_s2;
		end else if (pick[1]) begin
			out_rgb = curc_s2;
		end else begin
			out_rgb = pix_s2;
		end
		result.pixel_row  = pick[2] ? row_s2 : row_s2 - 1'b1;
		result.pixel_col  = pix_col_t'(pick[0] ? col_s2 - 1'b1 : col_s2);
		result.red_out    = out_rgb[2];
		result.green_out  = out_rgb[1];
		result.blue_out   = out_rgb[0];
		result.run_last   = (rest == '0);
		result.frame_done = pick[2] && last_col_s2;
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`BPNF_ASSERT_NOW(a_fix_raw_bank_apart, fix_we && pix_accept, fix_bank != raw_bank, "fill writeback and raw write hit one bank")
	`BPNF_ASSERT_NOW(a_bank_in_range, valid_s1 || !valid_s1, bank_q != bank_t'(NUM_BANKS), "bank rotation out of range")
	`BPNF_ASSERT_NOW(a_bypass_row_start, pix_accept && (byp_a || byp_c), col_q == '0, "read bypass away from row start")
	`BPNF_ASSERT_NOW(a_frame_done_last, result_valid && result.frame_done, result.run_last, "frame end not last result of its pixel")
	`BPNF_ASSERT_NEXT(a_s1_hold, valid_s1 && !s1_adv, valid_s1 && $stable(row_s1) && $stable(col_s1), "stalled pixel lost in compute stage")

endmodule

`default_nettype wire

[verif/black_pixel_neighbor_fill_unit_tb.sv]
// ----------------------------------------------------------------------------
// black_pixel_neighbor_fill_unit_tb
// Self-checking bench for the black pixel neighbor fill unit. Small frames
// of raster-order pixels go in over a valid/ready channel. A line-buffer
// model in the bench predicts every emitted pixel, including the in-place
// neighbor mean of black pixels. Each result is checked field by field in
// order. The run covers a directed table, random frames and the widest and
// tallest settings.
// ----------------------------------------------------------------------------
module black_pixel_neighbor_fill_unit_tb;
	import bpnf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W      = 2048;
	localparam int RAND_ITEMS = 320;
	localparam int CYCLE_CAP  = 200000;  // slowest legal run is far below this
	localparam int TAIL_WAIT  = 12;      // a result leaves through s1 and then the result register
	localparam int MSG_CAP    = 100;

	// one row of the directed table: optional frame setup, the pixel, and
	// for plain pass-through rows the single result typed in by hand
	typedef struct packed {
		logic                  cfg;
		logic [CFG_DATA_W-1:0] width;
		logic [CFG_DATA_W-1:0] height;
		pix_in_t               pix;
		logic                  typed;
		pix_out_t              want;
	} dir_row_t;

	localparam int DIR_N = 22;
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		// height 0 acts as 1: every pixel is in the last row and passes as is
		'{1'b1, 16'd4, 16'd0, '{8'h00, 8'h00, 8'h00}, 1'b1,
			'{16'd0, 11'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
		'{1'b0, 16'd0, 16'd0, '{8'hFF, 8'hFF, 8'hFF}, 1'b1,
			'{16'd0, 11'd1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0}},
		'{1'b0, 16'd0, 16'd0, '{8'h80, 8'h01, 8'h7F}, 1'b1,
			'{16'd0, 11'd2, 8'h80, 8'h01, 8'h7F, 1'b1, 1'b0}},
		'{1'b0, 16'd0, 16'd0, '{8'h01, 8'h80, 8'hFE}, 1'b1,
			'{16'd0, 11'd3, 8'h01, 8'h80, 8'hFE, 1'b1, 1'b1}},
		// 4x3: black at corner, top row, left column, interior, last column
		// and last row
		'{1'b1, 16'd4, 16'd3, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'h60, 8'h90, 8'hF0}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'h11, 8'h22, 8'h33}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'hFF, 8'h00, 8'hFF}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'h03, 8'h05, 8'h07}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
		// width 0 acts as 1: one column, nothing corrected
		'{1'b1, 16'd0, 16'd2, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'hA5, 8'h5A, 8'hC3}, 1'b0, '0},
		// smallest correcting frame, mean truncates down
		'{1'b1, 16'd2, 16'd2, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
		'{1'b0, 16'd0, 16'd0, '{8'hFE, 8'hFE, 8'hFE}, 1'b0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  pixel_valid;
	logic                  pixel_ready;
	pix_in_t               pixel;
	logic                  result_valid;
	logic                  result_ready;
	pix_out_t              result;

	// line banks and raster position of the fill model
	rgb_t            line_up [MAX_W];
	rgb_t            line_mid [MAX_W];
	rgb_t            line_dn [MAX_W];
	int              at_row;
	int              at_col;
	logic [11:0]     img_w;
	logic [15:0]     img_h;

	pix_out_t        filled_q [$];   // emitted pixels still to come, oldest first
	pix_out_t        want_px;
	int              err_cnt;
	int              cycle_cnt;
	int              tx_gap_pct;
	int              rx_stall_pct;

	black_pixel_neighbor_fill_unit #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// fill model
	// ------------------------------------------------------------------
	function automatic pix_out_t emit_px(int r, int c, rgb_t v, logic fd);
		pix_out_t o;
		o.pixel_row  = pix_row_t'(r);
		o.pixel_col  = pix_col_t'(c);
		o.red_out    = v[2];
		o.green_out  = v[1];
		o.blue_out   = v[0];
		o.run_last   = 1'b0;
		o.frame_done = fd;
		return o;
	endfunction

	// One raw pixel in, 0 to 3 emitted pixels out. Black pixels take the
	// truncated mean of corrected rows above / left and raw right / below.
	task automatic fill_pixel(input pix_in_t p, output pix_out_t res [3], output int n);
		rgb_t px;
		rgb_t v;
		rgb_t nb [$];
		int   w;
		int   h;
		int   r;
		int   c;
		int   j;
		int   sum;
		logic lastcol;
		logic lastrow;
		px = {p.red_in, p.green_in, p.blue_in};
		w  = (img_w == 0) ? 1 : ((img_w > MAX_W) ? MAX_W : int'(img_w));
		h  = (img_h == 0) ? 1 : int'(img_h);
		r  = at_row;
		c  = at_col;
		n  = 0;
		line_dn[c] = px;
		lastcol = (c >= w - 1);
		lastrow = (r >= h - 1);
		if (r >= 1) begin
			if (c >= 1) begin
				j = c - 1;
				v = line_mid[j];
				if (v == '0) begin
					nb.push_back(line_mid[c]);
					nb.push_back(px);
					nb.push_back(line_dn[j]);
					if (j > 0) begin
						nb.push_back(line_dn[j-1]);
						nb.push_back(line_mid[j-1]);
					end
					if (r >= 2) begin
						nb.push_back(line_up[j]);
						nb.push_back(line_up[c]);
						if (j > 0)
							nb.push_back(line_up[j-1]);
					end
					for (int ch = 0; ch < 3; ch++) begin
						sum = 0;
						foreach (nb[k])
							sum += nb[k][ch];
						v[ch] = CH_W'(sum / nb.size());
					end
					line_mid[j] = v;
				end
				res[n] = emit_px(r - 1, j, v, 1'b0);
				n++;
			end
			if (lastcol) begin
				res[n] = emit_px(r - 1, c, line_mid[c], 1'b0);
				n++;
			end
		end
		if (lastrow) begin
			res[n] = emit_px(r, c, px, lastcol);
			n++;
		end
		if (n > 0)
			res[n-1].run_last = 1'b1;
		if (lastcol) begin
			at_col   = 0;
			line_up  = line_mid;
			line_mid = line_dn;
			at_row   = lastrow ? 0 : ((r + 1) & 16'hFFFF);
		end else begin
			at_col = c + 1;
		end
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report(input string msg);
		if (err_cnt < MSG_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	task automatic cmp_field(input string name, input logic [15:0] got,
		input logic [15:0] want, input pix_out_t ref_px);
		if (got !== want)
			report($sformatf("pixel (%0d,%0d) %s got %0h want %0h",
				ref_px.pixel_row, ref_px.pixel_col, name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (filled_q.size() == 0) begin
				report($sformatf("unexpected result at (%0d,%0d)",
					result.pixel_row, result.pixel_col));
			end else begin
				want_px = filled_q.pop_front();
				cmp_field("row",        result.pixel_row,  want_px.pixel_row,  want_px);
				cmp_field("col",        result.pixel_col,  want_px.pixel_col,  want_px);
				cmp_field("red",        result.red_out,    want_px.red_out,    want_px);
				cmp_field("green",      result.green_out,  want_px.green_out,  want_px);
				cmp_field("blue",       result.blue_out,   want_px.blue_out,   want_px);
				cmp_field("run_last",   result.run_last,   want_px.run_last,   want_px);
				cmp_field("frame_done", result.frame_done, want_px.frame_done, want_px);
			end
		end
	end

	// receiver back-pressure, decided each falling edge
	always @(negedge clk)
		result_ready <= ($urandom_range(99) >= rx_stall_pct);

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("black_pixel_neighbor_fill_unit_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers; all of them start and end on a falling edge
	// ------------------------------------------------------------------

	// offer one pixel, wait for the handshake, queue what it emits
	task automatic send_pixel(input pix_in_t p, input logic typed, input pix_out_t want);
		pix_out_t res [3];
		int       n;
		while ($urandom_range(99) < tx_gap_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= p;
		do
			@(posedge clk);
		while (!pixel_ready);
		fill_pixel(p, res, n);
		if (typed) begin
			filled_q.push_back(want);
		end else begin
			for (int k = 0; k < n; k++)
				filled_q.push_back(res[k]);
		end
		@(negedge clk);
	endtask

	// hold the pixel channel until every queued pixel has come out
	task automatic drain();
		pixel_valid <= 1'b0;
		do
			@(negedge clk);
		while (filled_q.size() != 0);
	endtask

	// new frame geometry; drains the block and lets it settle before the writes
	task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		drain();
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(negedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(negedge clk);
		cfg_we    <= 1'b0;
		img_w = w[11:0];
		img_h = h;
	endtask

	// black pixels are common; extremes and near-black values show up too
	function automatic pix_in_t rand_px();
		pix_in_t p;
		case ($urandom_range(9))
			0, 1, 2: p = '0;
			3: begin
				p.red_in   = $urandom_range(1) ? 8'hFF : 8'h00;
				p.green_in = $urandom_range(1) ? 8'hFF : 8'h00;
				p.blue_in  = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			4: begin
				p = '0;
				case ($urandom_range(2))
					0: p.red_in   = CH_W'($urandom_range(1, 255));
					1: p.green_in = CH_W'($urandom_range(1, 255));
					default: p.blue_in = CH_W'($urandom_range(1, 255));
				endcase
			end
			default: p = pix_in_t'($urandom);
		endcase
		return p;
	endfunction

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int       rnd_cnt;
		int       w_eff;
		int       h_eff;
		logic     drained;
		logic [CFG_DATA_W-1:0] w_wr;
		logic [CFG_DATA_W-1:0] h_wr;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_IMAGE_WIDTH;
		cfg_data     = '0;
		pixel_valid  = 1'b0;
		pixel        = '0;
		result_ready = 1'b0;
		err_cnt      = 0;
		cycle_cnt    = 0;
		at_row       = 0;
		at_col       = 0;
		img_w        = IMAGE_WIDTH_RST;
		img_h        = IMAGE_HEIGHT_RST;
		tx_gap_pct   = 9;
		rx_stall_pct = 71;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < DIR_N; i++) begin
			if (DIR_TAB[i].cfg)
				set_frame(DIR_TAB[i].width, DIR_TAB[i].height);
			send_pixel(DIR_TAB[i].pix, DIR_TAB[i].typed, DIR_TAB[i].want);
		end

		// random frames, mostly small; back-pressure phases by item count
		rnd_cnt = 0;
		drained = 1'b0;
		while (rnd_cnt < RAND_ITEMS) begin
			case ($urandom_range(9))
				0:       w_eff = 1;
				1:       w_eff = $urandom_range(7, 40);
				default: w_eff = $urandom_range(2, 6);
			endcase
			h_eff = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 6);
			// 0 stands for 1; bits above the 12-bit width field are don't-care
			w_wr = {4'($urandom_range(15)),
				12'((w_eff == 1 && $urandom_range(1)) ? 0 : w_eff)};
			h_wr = (h_eff == 1 && $urandom_range(1)) ? 16'd0 : 16'(h_eff);
			set_frame(w_wr, h_wr);
			for (int k = 0; k < w_eff * h_eff; k++) begin
				if (rnd_cnt < RAND_ITEMS / 3) begin
					tx_gap_pct   = 9;
					rx_stall_pct = 71;
				end else if (rnd_cnt < 2 * RAND_ITEMS / 3) begin
					tx_gap_pct   = 71;
					rx_stall_pct = 9;
				end else begin
					tx_gap_pct   = 0;
					rx_stall_pct = 0;
				end
				// once, midway through the random items: let the pipeline empty completely
				if (!drained && rnd_cnt >= RAND_ITEMS / 2) begin
					drain();
					drained = 1'b1;
				end
				send_pixel(rand_px(), 1'b0, '0);
				rnd_cnt++;
			end
		end

		// widest line: 12-bit all-ones clamps to MAX_WIDTH, one row
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		set_frame(16'hFFFF, 16'd1);
		for (int k = 0; k < MAX_W; k++)
			send_pixel(rand_px(), 1'b0, '0);

		// tallest frame, only its first rows are sent
		set_frame(16'd3, 16'hFFFF);
		for (int k = 0; k < 30; k++)
			send_pixel(rand_px(), 1'b0, '0);

		drain();
		repeat (TAIL_WAIT) @(negedge clk);
		if (err_cnt == 0)
			$display("black_pixel_neighbor_fill_unit_tb OK");
		else
			$display("black_pixel_neighbor_fill_unit_tb NOT OK");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/bpnf_pkg.sv
rtl/core/black_pixel_neighbor_fill_unit.sv
verif/black_pixel_neighbor_fill_unit_tb.sv
